/* src/rtr_pkg.sv */
// Roman numeral encoder: shared types, widths and letter codes.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package rtr_pkg;

  localparam int unsigned NumW = 12;
  localparam int unsigned SymW = 7;
  localparam int unsigned ValW = 10;
  localparam int unsigned PcW  = 5;

  localparam logic [NumW-1:0] MaxValid = 12'd3999;

  localparam logic [SymW-1:0] ChI = 7'h49;
  localparam logic [SymW-1:0] ChV = 7'h56;
  localparam logic [SymW-1:0] ChX = 7'h58;
  localparam logic [SymW-1:0] ChL = 7'h4C;
  localparam logic [SymW-1:0] ChC = 7'h43;
  localparam logic [SymW-1:0] ChD = 7'h44;
  localparam logic [SymW-1:0] ChM = 7'h4D;

  // LOOP: emit and subtract while rest >= value, else fall through.
  // PAIR_HI: emit first letter of a subtractive pair, else skip the pair.
  // PAIR_LO: emit second letter and subtract.
  typedef enum logic [1:0] {
    OP_LOOP,
    OP_PAIR_HI,
    OP_PAIR_LO
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [ValW-1:0] value;
    logic [SymW-1:0] letter;
  } uword_t;

  typedef struct packed {
    logic            load;
    logic            emit;
    logic            sub;
    logic [ValW-1:0] value;
    logic [SymW-1:0] letter;
  } ctl_t;

  typedef struct packed {
    logic ge;
    logic zero;
    logic num_ok;
    logic out_free;
  } stat_t;

endpackage

/* src/rtr_in_if.sv */
// Request channel of the Roman numeral encoder: valid/ready plus number.
// Depends on rtr_pkg.
`timescale 1ns / 1ps

interface rtr_in_if;
  logic                      valid;
  logic                      ready;
  logic [rtr_pkg::NumW-1:0]  number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

/* src/rtr_out_if.sv */
// Result channel of the Roman numeral encoder: one letter per result beat.
// Depends on rtr_pkg.
`timescale 1ns / 1ps

interface rtr_out_if;
  logic                      valid;
  logic                      ready;
  logic [rtr_pkg::SymW-1:0]  symbol;
  logic                      last;
  logic                      error;

  modport source (output valid, output symbol, output last, output error, input ready);
  modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

/* src/rtr_ucode_rom.sv */
// Microcode store: one control word per program step of the greedy conversion.
// Depends on rtr_pkg.
`timescale 1ns / 1ps

module rtr_ucode_rom (
  input  logic [rtr_pkg::PcW-1:0] pc_i,
  output rtr_pkg::uword_t         uword_o
);

  always_comb begin
    unique case (pc_i)
      5'd0:    uword_o = '{rtr_pkg::OP_LOOP,    10'd1000, rtr_pkg::ChM};
      5'd1:    uword_o = '{rtr_pkg::OP_PAIR_HI, 10'd900,  rtr_pkg::ChC};
      5'd2:    uword_o = '{rtr_pkg::OP_PAIR_LO, 10'd900,  rtr_pkg::ChM};
      5'd3:    uword_o = '{rtr_pkg::OP_LOOP,    10'd500,  rtr_pkg::ChD};
      5'd4:    uword_o = '{rtr_pkg::OP_PAIR_HI, 10'd400,  rtr_pkg::ChC};
      5'd5:    uword_o = '{rtr_pkg::OP_PAIR_LO, 10'd400,  rtr_pkg::ChD};
      5'd6:    uword_o = '{rtr_pkg::OP_LOOP,    10'd100,  rtr_pkg::ChC};
      5'd7:    uword_o = '{rtr_pkg::OP_PAIR_HI, 10'd90,   rtr_pkg::ChX};
      5'd8:    uword_o = '{rtr_pkg::OP_PAIR_LO, 10'd90,   rtr_pkg::ChC};
      5'd9:    uword_o = '{rtr_pkg::OP_LOOP,    10'd50,   rtr_pkg::ChL};
      5'd10:   uword_o = '{rtr_pkg::OP_PAIR_HI, 10'd40,   rtr_pkg::ChX};
      5'd11:   uword_o = '{rtr_pkg::OP_PAIR_LO, 10'd40,   rtr_pkg::ChL};
      5'd12:   uword_o = '{rtr_pkg::OP_LOOP,    10'd10,   rtr_pkg::ChX};
      5'd13:   uword_o = '{rtr_pkg::OP_PAIR_HI, 10'd9,    rtr_pkg::ChI};
      5'd14:   uword_o = '{rtr_pkg::OP_PAIR_LO, 10'd9,    rtr_pkg::ChX};
      5'd15:   uword_o = '{rtr_pkg::OP_LOOP,    10'd5,    rtr_pkg::ChV};
      5'd16:   uword_o = '{rtr_pkg::OP_PAIR_HI, 10'd4,    rtr_pkg::ChI};
      5'd17:   uword_o = '{rtr_pkg::OP_PAIR_LO, 10'd4,    rtr_pkg::ChV};
      default: uword_o = '{rtr_pkg::OP_LOOP,    10'd1,    rtr_pkg::ChI};
    endcase
  end

endmodule

/* src/rtr_sequencer.sv */
// Step counter and jump logic: walks the microcode and drives the datapath.
// Depends on rtr_pkg and rtr_ucode_rom.
`timescale 1ns / 1ps

module rtr_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rtr_pkg::stat_t stat_i,
  output rtr_pkg::ctl_t  ctl_o
);

  logic [rtr_pkg::PcW-1:0] pc_q, pc_d;
  logic                    busy_q, busy_d;
  rtr_pkg::uword_t         uw;
  logic                    step;

  rtr_ucode_rom u_rom (
    .pc_i    (pc_q),
    .uword_o (uw)
  );

  assign in_ready_o = !busy_q && stat_i.out_free;
  assign step       = busy_q && stat_i.out_free;

  always_comb begin
    pc_d         = pc_q;
    busy_d       = busy_q;
    ctl_o.load   = in_valid_i && in_ready_o;
    ctl_o.emit   = 1'b0;
    ctl_o.sub    = 1'b0;
    ctl_o.value  = uw.value;
    ctl_o.letter = uw.letter;

    if (ctl_o.load) begin
      pc_d   = '0;
      busy_d = stat_i.num_ok;
    end else if (step) begin
      unique case (uw.op)
        rtr_pkg::OP_LOOP: begin
          if (stat_i.ge) begin
            ctl_o.emit = 1'b1;
            ctl_o.sub  = 1'b1;
            if (stat_i.zero) busy_d = 1'b0;
          end else begin
            pc_d = pc_q + rtr_pkg::PcW'(1);
          end
        end
        rtr_pkg::OP_PAIR_HI: begin
          if (stat_i.ge) begin
            ctl_o.emit = 1'b1;
            pc_d       = pc_q + rtr_pkg::PcW'(1);
          end else begin
            pc_d = pc_q + rtr_pkg::PcW'(2);
          end
        end
        rtr_pkg::OP_PAIR_LO: begin
          ctl_o.emit = 1'b1;
          ctl_o.sub  = 1'b1;
          pc_d       = pc_q + rtr_pkg::PcW'(1);
          if (stat_i.zero) busy_d = 1'b0;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

endmodule

/* src/rtr_datapath.sv */
// Remainder register, compare/subtract unit and result register.
// Depends on rtr_pkg.
`timescale 1ns / 1ps

module rtr_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [rtr_pkg::NumW-1:0] number_i,
  input  rtr_pkg::ctl_t            ctl_i,
  output rtr_pkg::stat_t           stat_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [rtr_pkg::SymW-1:0] symbol_o,
  output logic                     last_o,
  output logic                     error_o
);

  logic [rtr_pkg::NumW-1:0] rest_q;
  logic [rtr_pkg::NumW-1:0] value_ext;
  logic [rtr_pkg::NumW-1:0] diff;
  logic                     num_ok;
  logic                     out_valid_q;
  logic [rtr_pkg::SymW-1:0] symbol_q;
  logic                     last_q;
  logic                     error_q;
  logic                     err_load;

  assign value_ext = {{(rtr_pkg::NumW - rtr_pkg::ValW){1'b0}}, ctl_i.value};
  assign diff      = rest_q - value_ext;
  assign num_ok    = (number_i != '0) && (number_i <= rtr_pkg::MaxValid);
  assign err_load  = ctl_i.load && !num_ok;

  assign stat_o.ge       = rest_q >= value_ext;
  assign stat_o.zero     = diff == '0;
  assign stat_o.num_ok   = num_ok;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rest_q <= number_i;
    end else if (ctl_i.sub) begin
      rest_q <= diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit || err_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (err_load) begin
      symbol_q <= '0;
      last_q   <= 1'b1;
      error_q  <= 1'b1;
    end else if (ctl_i.emit) begin
      symbol_q <= ctl_i.letter;
      last_q   <= ctl_i.sub && stat_o.zero;
      error_q  <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;
  assign error_o     = error_q;

endmodule

/* src/integer_to_roman_encoder_core.sv */
// Roman numeral encoder top level: microcoded sequencer plus datapath.
// Depends on rtr_pkg, rtr_in_if, rtr_out_if, rtr_sequencer, rtr_datapath.
//
//   port    dir  payload                 role
//   req_i   in   number_in[11:0]         one integer per request
//   rsp_o   out  symbol[6:0] last error  one ASCII letter per beat
//
// One program step per cycle after the accepting edge, while the result register
// is free: each letter takes one step, each untaken test of the microcode one
// more (at most 12).
// Out-of-range numbers give their single error result in the cycle after acceptance.
// A new request is taken after the last letter, once the result register is free.
// Reset clears the step counter, busy flag and result valid; nothing else.
// A stalled result register stalls the sequencer.
`timescale 1ns / 1ps

module integer_to_roman_encoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtr_in_if.sink      req_i,
  rtr_out_if.source   rsp_o
);

  rtr_pkg::ctl_t  ctl;
  rtr_pkg::stat_t stat;

  rtr_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  rtr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (req_i.number_in),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .symbol_o    (rsp_o.symbol),
    .last_o      (rsp_o.last),
    .error_o     (rsp_o.error)
  );

endmodule

/* src/rtr_checker.sv */
// Port-level checks for the Roman numeral encoder, bound to the top level.
// Depends on rtr_pkg and integer_to_roman_encoder_core.
`timescale 1ns / 1ps

module rtr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic [rtr_pkg::NumW-1:0] number_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [rtr_pkg::SymW-1:0] symbol_i,
  input logic                     last_i,
  input logic                     error_i
);

  logic in_acc;
  logic bad_num;

  assign in_acc  = in_valid_i && in_ready_i;
  assign bad_num = (number_i == '0) || (number_i > rtr_pkg::MaxValid);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(symbol_i) && $stable(last_i) && $stable(error_i))
    else $error("result changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_i |-> last_i && (symbol_i == '0))
    else $error("error beat not a single empty beat");

  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !error_i |->
      (symbol_i == rtr_pkg::ChI) || (symbol_i == rtr_pkg::ChV) ||
      (symbol_i == rtr_pkg::ChX) || (symbol_i == rtr_pkg::ChL) ||
      (symbol_i == rtr_pkg::ChC) || (symbol_i == rtr_pkg::ChD) ||
      (symbol_i == rtr_pkg::ChM))
    else $error("symbol is not a numeral letter");

  a_bad_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && bad_num |=> out_valid_i && error_i)
    else $error("out-of-range request gave no error beat");

endmodule

bind integer_to_roman_encoder_core rtr_checker u_rtr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .number_i    (req_i.number_in),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .symbol_i    (rsp_o.symbol),
  .last_i      (rsp_o.last),
  .error_i     (rsp_o.error)
);

/* dv/tb_integer_to_roman_encoder_core.sv */
// Testbench for integer_to_roman_encoder_core: random valid/ready traffic, a built-in
// greedy Roman numeral predictor and a per-letter scoreboard check.
// Depends on rtr_pkg, rtr_in_if, rtr_out_if and the encoder core.
`timescale 1ns / 1ps

module tb_integer_to_roman_encoder_core;

  localparam int unsigned NumGroups = 13;
  localparam logic [rtr_pkg::SymW-1:0] NoLetter = '0;

  typedef struct {
    logic [rtr_pkg::SymW-1:0] symbol;
    logic                     last;
    logic                     error;
  } letter_t;

  logic clk;
  logic rst_n;
  bit   no_gaps;
  int   mismatches;

  letter_t roman_q[$];

  rtr_in_if  req_if ();
  rtr_out_if rsp_if ();

  integer_to_roman_encoder_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned group_value(input int g);
    case (g)
      0:       return 1000;
      1:       return 900;
      2:       return 500;
      3:       return 400;
      4:       return 100;
      5:       return 90;
      6:       return 50;
      7:       return 40;
      8:       return 10;
      9:       return 9;
      10:      return 5;
      11:      return 4;
      default: return 1;
    endcase
  endfunction

  function automatic logic [rtr_pkg::SymW-1:0] group_lead(input int g);
    case (g)
      0:       return rtr_pkg::ChM;
      1, 3, 4: return rtr_pkg::ChC;
      2:       return rtr_pkg::ChD;
      5, 7, 8: return rtr_pkg::ChX;
      6:       return rtr_pkg::ChL;
      10:      return rtr_pkg::ChV;
      default: return rtr_pkg::ChI;
    endcase
  endfunction

  function automatic logic [rtr_pkg::SymW-1:0] group_tail(input int g);
    case (g)
      1:       return rtr_pkg::ChM;
      3:       return rtr_pkg::ChD;
      5:       return rtr_pkg::ChC;
      7:       return rtr_pkg::ChL;
      9:       return rtr_pkg::ChX;
      11:      return rtr_pkg::ChV;
      default: return NoLetter;
    endcase
  endfunction

  // Greedy conversion; queues every letter the request should produce.
  task automatic push_roman(input logic [rtr_pkg::NumW-1:0] num);
    int unsigned rest;
    letter_t     item;
    rest = 32'(num);
    if (num == '0 || num > rtr_pkg::MaxValid) begin
      item.symbol = NoLetter;
      item.last   = 1'b1;
      item.error  = 1'b1;
      roman_q.push_back(item);
      return;
    end
    item.error = 1'b0;
    for (int g = 0; g < NumGroups; g++) begin
      while (rest >= group_value(g)) begin
        rest        = rest - group_value(g);
        item.symbol = group_lead(g);
        item.last   = (rest == 0) && (group_tail(g) == NoLetter);
        roman_q.push_back(item);
        if (group_tail(g) != NoLetter) begin
          item.symbol = group_tail(g);
          item.last   = (rest == 0);
          roman_q.push_back(item);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && req_if.valid && req_if.ready) begin
      push_roman(req_if.number_in);
    end
  end

  always @(posedge clk) begin
    letter_t exp_l;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (roman_q.size() == 0) begin
        $error("unexpected result: symbol %0h last %0b error %0b",
               rsp_if.symbol, rsp_if.last, rsp_if.error);
        mismatches++;
      end else begin
        exp_l = roman_q.pop_front();
        if (rsp_if.symbol !== exp_l.symbol) begin
          $error("symbol: expected %0h, got %0h", exp_l.symbol, rsp_if.symbol);
          mismatches++;
        end
        if (rsp_if.last !== exp_l.last) begin
          $error("last: expected %0b, got %0b", exp_l.last, rsp_if.last);
          mismatches++;
        end
        if (rsp_if.error !== exp_l.error) begin
          $error("error: expected %0b, got %0b", exp_l.error, rsp_if.error);
          mismatches++;
        end
      end
    end
  end

  // Result side: random stall before each beat.
  initial begin
    int gap;
    rsp_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(7);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
    end
  end

  task automatic send_number(input logic [rtr_pkg::NumW-1:0] num);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(7);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.number_in <= num;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [rtr_pkg::NumW-1:0] nums[$];
    nums = {12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
            12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000,
            12'd2047, 12'd2048, 12'd1994, 12'd3, 12'd1111, 12'd444, 12'd999};
    foreach (nums[i]) send_number(nums[i]);
  endtask

  task automatic test_random_valid(input int count);
    repeat (count) send_number(rtr_pkg::NumW'($urandom_range(1, 3999)));
  endtask

  // Out-of-range values mixed with the full 12-bit space.
  task automatic test_random_noise(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(2);
      case (pick)
        0:       send_number('0);
        1:       send_number(rtr_pkg::NumW'($urandom_range(4000, 4095)));
        default: send_number(rtr_pkg::NumW'($urandom_range(4095)));
      endcase
    end
  endtask

  task automatic test_back_to_back(input int count);
    no_gaps = 1'b1;
    test_random_valid(count);
    no_gaps = 1'b0;
  endtask

  initial begin
    mismatches       = 0;
    no_gaps          = 1'b0;
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.number_in = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_valid(280);
    test_random_noise(60);
    test_back_to_back(70);

    req_if.valid <= 1'b0;
    @(posedge clk);
    while (roman_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
src/rtr_pkg.sv
src/rtr_in_if.sv
src/rtr_out_if.sv
src/rtr_ucode_rom.sv
src/rtr_sequencer.sv
src/rtr_datapath.sv
src/integer_to_roman_encoder_core.sv
src/rtr_checker.sv
dv/tb_integer_to_roman_encoder_core.sv
